// ===== hdl/vurp_pkg.sv =====
`timescale 1ns / 1ps

package vurp_pkg;

    localparam int OBJECT_BYTES_DEF  = 256;
    localparam int PATTERN_BYTES_DEF = 8192;
    localparam int NAME_BYTES_DEF    = 2048;
    localparam int PALETTE_BYTES     = 32;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PEEK  = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADR = 3'd3;
    localparam logic [2:0] REG_OAMDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [1:0] MIRROR_VERT  = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ = 2'd1;

    localparam logic [1:0] REGION_PATTERN = 2'd0;
    localparam logic [1:0] REGION_NAME    = 2'd1;
    localparam logic [1:0] REGION_NONE    = 2'd2;
    localparam logic [1:0] REGION_PALETTE = 2'd3;

    localparam logic [1:0] SRC_VALUE   = 2'd0;
    localparam logic [1:0] SRC_OBJECT  = 2'd1;
    localparam logic [1:0] SRC_PALETTE = 2'd2;

    localparam logic [5:0] PALETTE_PAGE = 6'h3F;
    localparam logic [7:0] GRAY_MASK    = 8'h30;
    localparam logic [7:0] COLOR_MASK   = 8'h3F;

    typedef struct packed {
        logic       fill;
        logic [1:0] src;
        logic [1:0] region;
        logic       gray;
        logic [7:0] value;
    } pipe_t;

    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        logic [4:0] s;
        s = a[4:0];
        if (s[4] && (s[1:0] == 2'b00)) begin
            s[4] = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== hdl/video_unit_register_port_top.sv =====
// pipeline: an accepted request passes the memory stage (p1_reg) and then the output register (m_read_data_reg)
// throughput: one request per cycle while m_ready does not hold the output; each memory has one read and one write port
// a data-port read refills the read buffer when it leaves the memory stage, forwarded to the next request
// reset: aresetn synchronous active low, clears the register file, read buffer and pipeline valid flags;
// pipeline data registers and object, pattern, nametable and palette memories are not cleared
`timescale 1ns / 1ps

module video_unit_register_port_top #(
    parameter int OBJECT_BYTES  = vurp_pkg::OBJECT_BYTES_DEF,
    parameter int PATTERN_BYTES = vurp_pkg::PATTERN_BYTES_DEF,
    parameter int NAME_BYTES    = vurp_pkg::NAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_write_data,
    input  logic [2:0] s_status_set,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);
    import vurp_pkg::*;

    localparam int OBJ_AW  = $clog2(OBJECT_BYTES);
    localparam int PAT_AW  = $clog2(PATTERN_BYTES);
    localparam int NAME_AW = $clog2(NAME_BYTES);
    localparam int PAL_AW  = $clog2(PALETTE_BYTES);

    logic [1:0]  mirror_mode_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  oam_pointer_reg, oam_pointer_next;
    logic        write_toggle_reg, write_toggle_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic [14:0] temp_address_reg, temp_address_next;
    logic [15:0] video_address_reg, video_address_next;
    logic [7:0]  data_buffer_reg;

    logic  p1_valid_reg;
    pipe_t p1_reg, p1_next;
    logic        m_valid_reg;
    logic [7:0]  m_read_data_reg;

    logic [7:0] object_mem [OBJECT_BYTES];
    logic [7:0] pattern_mem [PATTERN_BYTES];
    logic [7:0] name_mem [NAME_BYTES];
    logic [7:0] palette_mem [PALETTE_BYTES];
    logic [7:0] obj_q, pat_q, name_q, pal_q;

    logic        accept, advance;
    logic [2:0]  status_now;
    logic [7:0]  buf_eff, vid_value, result;
    logic [13:0] vaddr;
    logic [1:0]  region;
    logic        name_table;
    logic [10:0] name_slot;
    logic [4:0]  pal_idx;
    logic        data_write, obj_write;
    logic [15:0] addr_step;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_read_data = m_read_data_reg;

    // address decode of the current video address
    assign vaddr = video_address_reg[13:0];
    assign name_table = (mirror_mode_reg == MIRROR_VERT) ? vaddr[10] : vaddr[11];
    assign name_slot = {name_table, vaddr[9:0]};
    assign pal_idx = pal_slot(vaddr);
    assign addr_step = control_reg[2] ? 16'd32 : 16'd1;

    always_comb begin
        if (!vaddr[13]) begin
            region = REGION_PATTERN;
        end else if (vaddr[13:8] == PALETTE_PAGE) begin
            region = REGION_PALETTE;
        end else if ((mirror_mode_reg == MIRROR_VERT) || (mirror_mode_reg == MIRROR_HORIZ)) begin
            region = REGION_NAME;
        end else begin
            region = REGION_NONE;
        end
    end

    // stage two: memory data selection
    always_comb begin
        unique case (p1_reg.region)
            REGION_PATTERN: vid_value = pat_q;
            REGION_NAME:    vid_value = name_q;
            REGION_PALETTE: vid_value = pal_q & (p1_reg.gray ? GRAY_MASK : COLOR_MASK);
            default:        vid_value = 8'd0;
        endcase
    end

    always_comb begin
        unique case (p1_reg.src)
            SRC_OBJECT:  result = obj_q;
            SRC_PALETTE: result = vid_value;
            default:     result = p1_reg.value;
        endcase
    end

    assign buf_eff = (p1_valid_reg && p1_reg.fill) ? vid_value : data_buffer_reg;

    assign status_now = status_reg | s_status_set;
    assign data_write = accept && (s_req_type == REQ_WRITE) && (s_reg_index == REG_DATA);
    assign obj_write  = accept && (s_req_type == REQ_WRITE) && (s_reg_index == REG_OAMDAT);

    // register file update for the accepted request
    always_comb begin
        control_next       = control_reg;
        mask_next          = mask_reg;
        status_next        = status_reg;
        oam_pointer_next   = oam_pointer_reg;
        write_toggle_next  = write_toggle_reg;
        fine_x_next        = fine_x_reg;
        temp_address_next  = temp_address_reg;
        video_address_next = video_address_reg;
        p1_next.fill   = 1'b0;
        p1_next.src    = SRC_VALUE;
        p1_next.region = region;
        p1_next.gray   = mask_reg[0];
        p1_next.value  = 8'd0;
        if (accept) begin
            status_next = status_now;
            unique case (s_req_type)
                REQ_PEEK: begin
                    unique case (s_reg_index)
                        REG_CTRL:   p1_next.value = control_reg;
                        REG_MASK:   p1_next.value = mask_reg;
                        REG_STATUS: p1_next.value = {status_now, 5'd0};
                        default:    p1_next.value = 8'd0;
                    endcase
                end
                REQ_READ: begin
                    unique case (s_reg_index)
                        REG_STATUS: begin
                            p1_next.value = {status_now, buf_eff[4:0]};
                            status_next = {1'b0, status_now[1:0]};
                            write_toggle_next = 1'b0;
                        end
                        REG_OAMDAT: p1_next.src = SRC_OBJECT;
                        REG_DATA: begin
                            p1_next.value = buf_eff;
                            p1_next.fill = 1'b1;
                            if (region == REGION_PALETTE) begin
                                p1_next.src = SRC_PALETTE;
                            end
                            video_address_next = video_address_reg + addr_step;
                        end
                        default: p1_next.value = 8'd0;
                    endcase
                end
                REQ_WRITE: begin
                    unique case (s_reg_index)
                        REG_CTRL: begin
                            control_next = s_write_data;
                            temp_address_next[11:10] = s_write_data[1:0];
                        end
                        REG_MASK:   mask_next = s_write_data;
                        REG_OAMADR: oam_pointer_next = s_write_data;
                        REG_OAMDAT: oam_pointer_next = oam_pointer_reg + 8'd1;
                        REG_SCROLL: begin
                            if (!write_toggle_reg) begin
                                fine_x_next = s_write_data[2:0];
                                temp_address_next[4:0] = s_write_data[7:3];
                            end else begin
                                temp_address_next[14:12] = s_write_data[2:0];
                                temp_address_next[9:5]   = s_write_data[7:3];
                            end
                            write_toggle_next = !write_toggle_reg;
                        end
                        REG_ADDR: begin
                            if (!write_toggle_reg) begin
                                temp_address_next[14:8] = {1'b0, s_write_data[5:0]};
                            end else begin
                                temp_address_next[7:0] = s_write_data;
                                video_address_next = {1'b0, temp_address_reg[14:8], s_write_data};
                            end
                            write_toggle_next = !write_toggle_reg;
                        end
                        REG_DATA: video_address_next = video_address_reg + addr_step;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_mode_reg   <= MIRROR_VERT;
            control_reg       <= '0;
            mask_reg          <= '0;
            status_reg        <= '0;
            oam_pointer_reg   <= '0;
            write_toggle_reg  <= 1'b0;
            fine_x_reg        <= '0;
            temp_address_reg  <= '0;
            video_address_reg <= '0;
            data_buffer_reg   <= '0;
            p1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mirror_mode_reg <= cfg_wr_data;
            end
            control_reg       <= control_next;
            mask_reg          <= mask_next;
            status_reg        <= status_next;
            oam_pointer_reg   <= oam_pointer_next;
            write_toggle_reg  <= write_toggle_next;
            fine_x_reg        <= fine_x_next;
            temp_address_reg  <= temp_address_next;
            video_address_reg <= video_address_next;
            if (p1_valid_reg && p1_reg.fill && advance) begin
                data_buffer_reg <= vid_value;
            end
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
        if (advance && p1_valid_reg) begin
            m_read_data_reg <= result;
        end
    end

    // memories: write on the request edge, registered read held until the next request
    always_ff @(posedge aclk) begin
        if (obj_write) begin
            object_mem[oam_pointer_reg[OBJ_AW-1:0]] <= s_write_data;
        end
        if (accept) begin
            obj_q <= object_mem[oam_pointer_reg[OBJ_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (data_write && (region == REGION_PATTERN)) begin
            pattern_mem[vaddr[PAT_AW-1:0]] <= s_write_data;
        end
        if (accept) begin
            pat_q <= pattern_mem[vaddr[PAT_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (data_write && (region == REGION_NAME)) begin
            name_mem[name_slot[NAME_AW-1:0]] <= s_write_data;
        end
        if (accept) begin
            name_q <= name_mem[name_slot[NAME_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (data_write && (region == REGION_PALETTE)) begin
            palette_mem[pal_idx[PAL_AW-1:0]] <= s_write_data;
        end
        if (accept) begin
            pal_q <= palette_mem[pal_idx[PAL_AW-1:0]];
        end
    end

`ifndef NO_ASSERTIONS
    a_data_read_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_req_type == REQ_READ) && (s_reg_index == REG_DATA))
        |=> (p1_valid_reg && p1_reg.fill))
        else $error("data read did not schedule a buffer refill");

    a_stage_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && advance) |=> m_valid_reg)
        else $error("request lost between memory stage and output");

    a_status_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_req_type == REQ_READ) && (s_reg_index == REG_STATUS))
        |=> (!write_toggle_reg && !status_reg[2]))
        else $error("status read did not clear toggle and flag");
`endif

endmodule
